[rtl/led_breathing_ramp_unit_defines.svh]
// ----------------------------------------------------------------------------
// led breathing ramp assertion macros
// concurrent check forms for the breathing ramp, used by lbr_ramp
// ----------------------------------------------------------------------------
`ifndef LED_BREATHING_RAMP_UNIT_DEFINES_SVH
`define LED_BREATHING_RAMP_UNIT_DEFINES_SVH

// same-cycle implication
`define LBR_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LBR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/lbr_pkg.sv]
// ----------------------------------------------------------------------------
// lbr_pkg
// constants, register codes and shared types of the led breathing ramp
// ----------------------------------------------------------------------------
`default_nettype none

package lbr_pkg;

  localparam int unsigned MAX_SPEED          = 2;
  localparam int unsigned NORMAL_SPEED       = 10;
  localparam int unsigned SPEED_UP_INTERVAL  = 100;
  localparam int unsigned COOL_DOWN_INTERVAL = 200;

  localparam int unsigned ELAPSED_W = 16;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned DELAY_W   = 8;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 8;

  localparam int unsigned SU_RW = $clog2(SPEED_UP_INTERVAL + 1);
  localparam int unsigned CD_RW = $clog2(COOL_DOWN_INTERVAL + 1);

  localparam int unsigned ELAPSED_CAP   = (NORMAL_SPEED - MAX_SPEED) * COOL_DOWN_INTERVAL;
  localparam int unsigned ELAPSED_CONST = SPEED_UP_INTERVAL * NORMAL_SPEED;

  localparam logic [ELAPSED_W-1:0] ELAPSED_CAP_V   = ELAPSED_W'(ELAPSED_CAP);
  localparam logic [ELAPSED_W-1:0] ELAPSED_CONST_V = ELAPSED_W'(ELAPSED_CONST);

  localparam logic [SU_RW-1:0] SU_REM_MAX = SU_RW'(SPEED_UP_INTERVAL - 1);
  localparam logic [CD_RW-1:0] CD_REM_MAX = CD_RW'(COOL_DOWN_INTERVAL - 1);

  localparam logic [ELAPSED_W-1:0] CONST_SU_Q   = ELAPSED_W'(ELAPSED_CONST / SPEED_UP_INTERVAL);
  localparam logic [SU_RW-1:0]     CONST_SU_REM = SU_RW'(ELAPSED_CONST % SPEED_UP_INTERVAL);
  localparam logic [ELAPSED_W-1:0] CONST_CD_Q   = ELAPSED_W'(ELAPSED_CONST / COOL_DOWN_INTERVAL);
  localparam logic [CD_RW-1:0]     CONST_CD_REM = CD_RW'(ELAPSED_CONST % COOL_DOWN_INTERVAL);

  localparam logic [DELAY_W-1:0] MAX_SPEED_D    = DELAY_W'(MAX_SPEED);
  localparam logic [DELAY_W-1:0] NORMAL_SPEED_D = DELAY_W'(NORMAL_SPEED);

  typedef enum logic [MODE_W-1:0] {
    MODE_ACCEL = 2'd0,
    MODE_COOL  = 2'd1,
    MODE_CONST = 2'd2
  } mode_t;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PWM_TOP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEVEL = 2'd3;

  localparam logic [MODE_W-1:0]  MODE_RST      = MODE_CONST;
  localparam logic               ENABLE_RST    = 1'b0;
  localparam logic [LEVEL_W-1:0] PWM_TOP_RST   = 8'd255;
  localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST = 8'd0;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               enable;
    logic [LEVEL_W-1:0] pwm_top;
    logic [LEVEL_W-1:0] min_level;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] duty;
    logic               written;
  } res_t;

endpackage

`default_nettype wire

[rtl/led_breathing_ramp_unit.sv]
// a result is registered and appears on out_valid in the cycle after its item is accepted
// throughput: one item per cycle; in_stall rises only while a result waits stalled
// the step delay comes from running quotients, so no divider sits in the tick path
// reset: synchronous active-low rst_n clears ramp and elapsed state, loads register defaults
// ----------------------------------------------------------------------------
// led_breathing_ramp_unit
// millisecond-tick driven triangle pwm duty generator with speed modes
// ----------------------------------------------------------------------------
`default_nettype none

module led_breathing_ramp_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbr_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_tick,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [lbr_pkg::LEVEL_W-1:0]        out_duty,
  output logic                               out_duty_written
);
  import lbr_pkg::*;

  cfg_t               cfg_r;
  logic               cfg_wr;
  logic               clear;
  logic               accept;
  logic               active;
  logic [DELAY_W-1:0] delay;
  res_t               res;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_duty_r;
  logic               out_written_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign clear     = cfg_wr && (cfg_index == CFG_ENABLE) && !cfg_wdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode      <= MODE_RST;
      cfg_r.enable    <= ENABLE_RST;
      cfg_r.pwm_top   <= PWM_TOP_RST;
      cfg_r.min_level <= MIN_LEVEL_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_MODE:      cfg_r.mode      <= cfg_wdata[MODE_W-1:0];
        CFG_ENABLE:    cfg_r.enable    <= cfg_wdata[0];
        CFG_PWM_TOP:   cfg_r.pwm_top   <= cfg_wdata[LEVEL_W-1:0];
        CFG_MIN_LEVEL: cfg_r.min_level <= cfg_wdata[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // output register frees when its item is taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign active   = accept && in_tick && cfg_r.enable;

  lbr_delay u_delay (
    .clk    (clk),
    .rst_n  (rst_n),
    .active (active),
    .mode   (cfg_r.mode),
    .delay  (delay)
  );

  lbr_ramp u_ramp (
    .clk    (clk),
    .rst_n  (rst_n),
    .active (active),
    .clear  (clear),
    .delay  (delay),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_duty_r    <= res.duty;
      out_written_r <= res.written;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_duty         = out_duty_r;
  assign out_duty_written = out_written_r;

endmodule

`default_nettype wire

[rtl/lbr_delay.sv]
// ----------------------------------------------------------------------------
// lbr_delay
// elapsed time tracking and per-tick step delay, with running quotients
// ----------------------------------------------------------------------------
`default_nettype none

module lbr_delay (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       active,
  input  wire logic [lbr_pkg::MODE_W-1:0] mode,
  output logic [lbr_pkg::DELAY_W-1:0]     delay
);
  import lbr_pkg::*;

  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [ELAPSED_W-1:0] su_q_r, su_q_nxt;
  logic [SU_RW-1:0]     su_rem_r, su_rem_nxt;
  logic [ELAPSED_W-1:0] cd_q_r, cd_q_nxt;
  logic [CD_RW-1:0]     cd_rem_r, cd_rem_nxt;

  always_comb begin
    elapsed_nxt = elapsed_r;
    su_q_nxt    = su_q_r;
    su_rem_nxt  = su_rem_r;
    cd_q_nxt    = cd_q_r;
    cd_rem_nxt  = cd_rem_r;
    delay       = '0;
    case (mode)
      MODE_ACCEL: begin
        if (elapsed_r != '0) begin
          elapsed_nxt = elapsed_r - 1'b1;
          if (su_rem_r == '0) begin
            su_q_nxt   = su_q_r - 1'b1;
            su_rem_nxt = SU_REM_MAX;
          end else begin
            su_rem_nxt = su_rem_r - 1'b1;
          end
          if (cd_rem_r == '0) begin
            cd_q_nxt   = cd_q_r - 1'b1;
            cd_rem_nxt = CD_REM_MAX;
          end else begin
            cd_rem_nxt = cd_rem_r - 1'b1;
          end
        end
        delay = su_q_nxt[DELAY_W-1:0] + MAX_SPEED_D;
      end
      MODE_COOL: begin
        if (elapsed_r < ELAPSED_CAP_V) begin
          elapsed_nxt = elapsed_r + 1'b1;
          if (su_rem_r == SU_REM_MAX) begin
            su_q_nxt   = su_q_r + 1'b1;
            su_rem_nxt = '0;
          end else begin
            su_rem_nxt = su_rem_r + 1'b1;
          end
          if (cd_rem_r == CD_REM_MAX) begin
            cd_q_nxt   = cd_q_r + 1'b1;
            cd_rem_nxt = '0;
          end else begin
            cd_rem_nxt = cd_rem_r + 1'b1;
          end
        end
        delay = cd_q_nxt[DELAY_W-1:0] + MAX_SPEED_D;
      end
      MODE_CONST: begin
        elapsed_nxt = ELAPSED_CONST_V;
        su_q_nxt    = CONST_SU_Q;
        su_rem_nxt  = CONST_SU_REM;
        cd_q_nxt    = CONST_CD_Q;
        cd_rem_nxt  = CONST_CD_REM;
        delay       = NORMAL_SPEED_D;
      end
      default: begin
        delay = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      su_q_r    <= '0;
      su_rem_r  <= '0;
      cd_q_r    <= '0;
      cd_rem_r  <= '0;
    end else if (active) begin
      elapsed_r <= elapsed_nxt;
      su_q_r    <= su_q_nxt;
      su_rem_r  <= su_rem_nxt;
      cd_q_r    <= cd_q_nxt;
      cd_rem_r  <= cd_rem_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/lbr_ramp.sv]
// ----------------------------------------------------------------------------
// lbr_ramp
// step counter, triangle brightness level and pwm compare register
// ----------------------------------------------------------------------------
`default_nettype none
`include "led_breathing_ramp_unit_defines.svh"

module lbr_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        active,
  input  wire logic                        clear,
  input  wire logic [lbr_pkg::DELAY_W-1:0] delay,
  input  wire lbr_pkg::cfg_t               cfg,
  output lbr_pkg::res_t                    res
);
  import lbr_pkg::*;

  logic [DELAY_W-1:0] cnt_r, cnt_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               rising_r, rising_nxt;
  logic [LEVEL_W-1:0] compare_r, compare_nxt;
  logic [DELAY_W-1:0] cnt_inc;
  logic               step;

  assign cnt_inc = cnt_r + 1'b1;
  assign step    = active && (cnt_inc >= delay);

  always_comb begin
    cnt_nxt     = cnt_r;
    level_nxt   = level_r;
    rising_nxt  = rising_r;
    compare_nxt = compare_r;
    if (active) begin
      cnt_nxt = cnt_inc;
    end
    if (step) begin
      cnt_nxt = '0;
      if (rising_r) begin
        if (level_r < cfg.pwm_top) begin
          level_nxt = level_r + 1'b1;
        end else begin
          rising_nxt = 1'b0;
        end
      end else begin
        if (level_r > cfg.min_level) begin
          level_nxt = level_r - 1'b1;
        end else begin
          rising_nxt = 1'b1;
        end
      end
      compare_nxt = level_nxt;
    end
    if (clear) begin
      compare_nxt = '0;
    end
  end

  assign res.duty    = cfg.enable ? compare_nxt : '0;
  assign res.written = step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      level_r   <= '0;
      rising_r  <= 1'b0;
      compare_r <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      level_r   <= level_nxt;
      rising_r  <= rising_nxt;
      compare_r <= compare_nxt;
    end
  end

  `LBR_ASSERT_NEXT(a_step_clears_cnt, clk, rst_n, step, cnt_r == '0, "counter not cleared after step")
  `LBR_ASSERT_NEXT(a_clear_compare, clk, rst_n, clear, compare_r == '0, "compare not cleared on disable")
  `LBR_ASSERT_NEXT(a_compare_tracks, clk, rst_n, step && !clear, compare_r == level_r, "compare not level")

endmodule

`default_nettype wire

[tb/led_breathing_ramp_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_breathing_ramp_checker
// watches the register, tick and duty channels of the breathing ramp, keeps
// its own copy of the ramp state and compares every duty result in order
// ----------------------------------------------------------------------------

module led_breathing_ramp_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  input  wire logic                          cfg_ready,
  input  wire logic [lbr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lbr_pkg::CFG_DAT_W-1:0] cfg_wdata,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic                          in_tick,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [lbr_pkg::LEVEL_W-1:0]   out_duty,
  input  wire logic                          out_duty_written,
  output int                                 mismatches,
  output int                                 results_seen,
  output int                                 results_owed
);
  import lbr_pkg::*;

  logic [MODE_W-1:0]    mode_r;
  logic                 enable_r;
  logic [LEVEL_W-1:0]   top_r;
  logic [LEVEL_W-1:0]   floor_r;
  logic [ELAPSED_W-1:0] elapsed;
  logic [DELAY_W-1:0]   step_cnt;
  logic [LEVEL_W-1:0]   level;
  logic [LEVEL_W-1:0]   compare;
  logic                 rising;

  res_t duty_queue[$];
  int   err_total  = 0;
  int   seen_total = 0;

  function automatic res_t ramp_step(input logic tick);
    logic [DELAY_W-1:0] delay;
    res_t r;
    r.written = 1'b0;
    if (tick && enable_r) begin
      delay = '0;
      case (mode_r)
        MODE_ACCEL: begin
          if (elapsed != '0) elapsed = elapsed - 1'b1;
          delay = DELAY_W'(elapsed / SPEED_UP_INTERVAL + MAX_SPEED);
        end
        MODE_COOL: begin
          if (elapsed < (NORMAL_SPEED - MAX_SPEED) * COOL_DOWN_INTERVAL)
            elapsed = elapsed + 1'b1;
          delay = DELAY_W'(elapsed / COOL_DOWN_INTERVAL + MAX_SPEED);
        end
        MODE_CONST: begin
          elapsed = ELAPSED_W'(SPEED_UP_INTERVAL * NORMAL_SPEED);
          delay   = DELAY_W'(NORMAL_SPEED);
        end
        default: ;
      endcase
      step_cnt = step_cnt + 1'b1;
      if (step_cnt >= delay) begin
        step_cnt = '0;
        if (rising) begin
          if (level < top_r) level = level + 1'b1;
          else rising = 1'b0;
        end else begin
          if (level > floor_r) level = level - 1'b1;
          else rising = 1'b1;
        end
        compare   = level;
        r.written = 1'b1;
      end
    end
    r.duty = enable_r ? compare : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      mode_r   = MODE_CONST;
      enable_r = 1'b0;
      top_r    = 8'd255;
      floor_r  = 8'd0;
      elapsed  = '0;
      step_cnt = '0;
      level    = '0;
      compare  = '0;
      rising   = 1'b0;
      duty_queue.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen_total++;
        if (duty_queue.size() == 0) begin
          err_total++;
          $display("%0t: unexpected item duty %0d written %0b", $time, out_duty,
                   out_duty_written);
        end else begin
          want = duty_queue.pop_front();
          if (out_duty !== want.duty) begin
            err_total++;
            $display("%0t: duty expected %0d actual %0d", $time, want.duty, out_duty);
          end
          if (out_duty_written !== want.written) begin
            err_total++;
            $display("%0t: duty_written expected %0b actual %0b", $time, want.written,
                     out_duty_written);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:      mode_r = cfg_wdata[MODE_W-1:0];
          CFG_ENABLE: begin
            enable_r = cfg_wdata[0];
            if (!cfg_wdata[0]) compare = '0;
          end
          CFG_PWM_TOP:   top_r   = cfg_wdata;
          CFG_MIN_LEVEL: floor_r = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) duty_queue.push_back(ramp_step(in_tick));
    end
    mismatches   <= err_total;
    results_seen <= seen_total;
    results_owed <= duty_queue.size();
  end

endmodule

[tb/led_breathing_ramp_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_breathing_ramp_unit_tb
// drives register settings and millisecond ticks into the breathing ramp with
// random idle bursts on both channels; the checker judges every duty item
// ----------------------------------------------------------------------------

module led_breathing_ramp_unit_tb;
  import lbr_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int QUIET_LIMIT = 1000;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata = '0;
  logic                 in_valid  = 1'b0;
  logic                 in_tick   = 1'b0;
  logic                 out_stall = 1'b0;
  wire                  cfg_ready;
  wire                  in_stall;
  wire                  out_valid;
  wire  [LEVEL_W-1:0]   out_duty;
  wire                  out_duty_written;

  int mismatches;
  int results_seen;
  int results_owed;
  int ticks_sent   = 0;
  int idle_pct     = 0;
  bit calm         = 1'b0;
  int stall_left   = 0;
  int quiet_cycles = 0;

  always #1 clk = ~clk;

  led_breathing_ramp_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick          (in_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .out_duty_written (out_duty_written)
  );

  led_breathing_ramp_checker u_ramp_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tick          (in_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_duty         (out_duty),
    .out_duty_written (out_duty_written),
    .mismatches       (mismatches),
    .results_seen     (results_seen),
    .results_owed     (results_owed)
  );

  // random result-side stall bursts
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(99) < idle_pct) begin
      stall_left <= $urandom_range(6);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (results_seen != ticks_sent) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_ramp(input logic [MODE_W-1:0] mode, input logic en,
                          input logic [LEVEL_W-1:0] top, input logic [LEVEL_W-1:0] floor);
    in_valid <= 1'b0;
    wait_drained();
    put_reg(CFG_MODE, {6'($urandom), mode});
    put_reg(CFG_ENABLE, {7'($urandom), en});
    put_reg(CFG_PWM_TOP, top);
    put_reg(CFG_MIN_LEVEL, floor);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_tick(input logic tick);
    if (!calm && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_tick  <= tick;
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  initial begin
    int                 sel;
    logic [MODE_W-1:0]  mode;
    logic [LEVEL_W-1:0] lo;
    logic [LEVEL_W-1:0] hi;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset defaults: disabled, duty zero
    send_tick(1'b1);
    send_tick(1'b0);
    // step every tick, turn at bottom and top of a narrow window
    set_ramp(MODE_SPARE, 1'b1, 8'd2, 8'd0);
    repeat (7) send_tick(1'b1);
    send_tick(1'b0);
    // floor above top
    set_ramp(MODE_SPARE, 1'b1, 8'd5, 8'd200);
    repeat (3) send_tick(1'b1);
    set_ramp(MODE_SPARE, 1'b1, 8'd255, 8'd255);
    repeat (2) send_tick(1'b1);
    // disable clears compare, stays zero after re-enable until next step
    set_ramp(MODE_CONST, 1'b0, 8'd255, 8'd0);
    send_tick(1'b1);
    set_ramp(MODE_CONST, 1'b1, 8'd255, 8'd0);
    send_tick(1'b0);
    send_tick(1'b1);
    set_ramp(MODE_ACCEL, 1'b1, 8'd0, 8'd0);
    repeat (3) send_tick(1'b1);
    set_ramp(MODE_COOL, 1'b1, 8'd255, 8'd0);
    repeat (2) send_tick(1'b1);

    for (int p = 0; p < 9; p++) begin
      idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 40);
      sel = $urandom_range(9);
      if (sel < 3) mode = MODE_ACCEL;
      else if (sel < 6) mode = MODE_COOL;
      else if (sel < 8) mode = MODE_CONST;
      else mode = MODE_SPARE;
      case ($urandom_range(3))
        0: begin
          lo = LEVEL_W'($urandom);
          hi = LEVEL_W'($urandom);
        end
        1: begin
          lo = LEVEL_W'($urandom_range(250));
          hi = lo + LEVEL_W'($urandom_range(5));
        end
        2: begin
          lo = $urandom_range(1) ? 8'd255 : 8'd0;
          hi = $urandom_range(1) ? 8'd255 : 8'd0;
        end
        default: begin
          hi = LEVEL_W'($urandom_range(100));
          lo = hi + LEVEL_W'($urandom_range(1, 150));
        end
      endcase
      set_ramp(mode, $urandom_range(7) != 0, hi, lo);
      if (p == 8) calm = 1'b1;
      repeat (55) send_tick($urandom_range(9) != 0);
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/lbr_pkg.sv
rtl/lbr_delay.sv
rtl/lbr_ramp.sv
rtl/led_breathing_ramp_unit.sv
tb/led_breathing_ramp_checker.sv
tb/led_breathing_ramp_unit_tb.sv
